>>> src/dmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_pkg: shared types and codes of the distributed mutex node
// Word layouts, command and result codes, register indexes, the phase
// encoding and the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dmn_pkg;

    // Field widths of the input and result words.
    localparam int CMD_W   = 2;
    localparam int ID_W    = 4;
    localparam int STAMP_W = 16;
    localparam int KIND_W  = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CLOCK = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [3:0]  RST_NODE_ID     = 4'd0;
    localparam logic [4:0]  RST_NODE_COUNT  = 5'd2;
    localparam logic [7:0]  RST_ENTRY_LIMIT = 8'd5;
    localparam logic [15:0] RST_START_CLOCK = 16'd1;

    // Input commands.
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MESSAGE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LEAVE   = 2'd2;

    // Message kinds.
    localparam logic MSG_REQUEST  = 1'b0;
    localparam logic MSG_RESPONSE = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] OUT_BROADCAST = 2'd0;
    localparam logic [KIND_W-1:0] OUT_RESPONSE  = 2'd1;
    localparam logic [KIND_W-1:0] OUT_GRANT     = 2'd2;

    // Input word.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic               msg_kind;
        logic [ID_W-1:0]    sender_id;
        logic [STAMP_W-1:0] sender_clock;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [KIND_W-1:0]  out_kind;
        logic [ID_W-1:0]    dest_id;
        logic [STAMP_W-1:0] stamp;
        logic               last;
    } t_out_word;

    // Protocol phase of the node.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_WAIT   = 3'b010,
        PH_INSIDE = 3'b100
    } t_phase;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic flush_go;
        logic last_entry;
    } t_dp_status;

endpackage
`default_nettype wire

>>> src/dmn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_ram: generic single-port-write RAM with registered read
// One write and one read address per cycle; read data is registered and
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module dmn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> src/dmn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_ctrl: sequencing controller of the mutex node
// Takes one word, lets the datapath execute it, then walks the deferred
// replies one at a time when a leave flushes them.
// ----------------------------------------------------------------------------
module dmn_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire dmn_pkg::t_dp_status i_status,
    output dmn_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_READ = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.emit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Execution waits for a free output register.
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_status.flush_go ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                // Wait state for the stamp memory read.
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.last_entry ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule
`default_nettype wire

>>> src/dmn_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_datapath: state, clock arithmetic and deferred table of the mutex node
// Holds the configuration, the Lamport clock, the phase and counters, the
// deferred-reply valid bits and stamp memory, and the output register.
// ----------------------------------------------------------------------------
module dmn_datapath #(
    parameter int MAX_NODES  = 16,
    parameter int CLOCK_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dmn_pkg::t_dp_cmd                    i_cmd,
    output dmn_pkg::t_dp_status                      o_status,
    input  wire dmn_pkg::t_in_word                   i_in_word,
    input  wire logic                                i_out_stall,
    output logic                                     o_out_valid,
    output dmn_pkg::t_out_word                       o_out_word,
    input  wire logic                                i_cfg_we,
    input  wire logic [dmn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dmn_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Only ids below both the table size and the id range can be deferred.
    localparam int TBL_DEPTH = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int RC_W      = $clog2(MAX_NODES);
    localparam int CMP_W     = (CLOCK_BITS > 16) ? CLOCK_BITS : 16;
    localparam logic [CLOCK_BITS-1:0] CLOCK_TOP = '1;

    // Configuration registers.
    logic [3:0] r_node_id;
    logic [4:0] r_node_count;
    logic [7:0] r_entry_limit;

    // Protocol state.
    logic [CLOCK_BITS-1:0] r_clock,   n_clock;
    logic [CLOCK_BITS-1:0] r_req,     n_req;
    dmn_pkg::t_phase       r_phase,   n_phase;
    logic [RC_W-1:0]       r_reply,   n_reply;
    logic [7:0]            r_entries, n_entries;
    logic [TBL_DEPTH-1:0]  r_valid,   n_valid;
    logic [TBL_DEPTH-1:0]  r_mask,    n_mask;

    // Captured input word and output register.
    dmn_pkg::t_in_word  r_in;
    logic               r_out_valid;
    dmn_pkg::t_out_word r_out_word;

    // Execution results.
    logic                  has_res;
    dmn_pkg::t_out_word    res_word;
    logic                  defer_hit;
    logic                  flush_go;
    logic [TBL_DEPTH-1:0]  flush_mask;
    logic [CLOCK_BITS-1:0] sclk;
    logic [CLOCK_BITS-1:0] clk_upd;
    logic [RC_W-1:0]       needed;
    logic [TBL_AW-1:0]     low_idx;
    logic [TBL_AW-1:0]     sid_idx;
    logic [15:0]           ram_rdata;
    logic [CLOCK_BITS-1:0] start_load;
    logic                  out_free;

    // Sender clock saturated to the clock width.
    always_comb begin
        logic [CMP_W-1:0] ext;
        ext  = CMP_W'(r_in.sender_clock);
        sclk = (ext > CMP_W'(CLOCK_TOP)) ? CLOCK_TOP : CLOCK_BITS'(ext);
    end

    // Start clock saturated to the clock width.
    always_comb begin
        logic [CMP_W-1:0] ext;
        ext        = CMP_W'(i_cfg_data);
        start_load = (ext > CMP_W'(CLOCK_TOP)) ? CLOCK_TOP : CLOCK_BITS'(ext);
    end

    // Lamport update: max of both clocks plus one, saturating at the top.
    always_comb begin
        logic [CLOCK_BITS-1:0] mx;
        mx      = (r_clock > sclk) ? r_clock : sclk;
        clk_upd = (mx == CLOCK_TOP) ? mx : mx + CLOCK_BITS'(1);
    end

    // Responses needed before entry, from a clamped node count.
    always_comb begin
        if (r_node_count < 5'd2) begin
            needed = RC_W'(1);
        end else if (int'(r_node_count) > MAX_NODES) begin
            needed = RC_W'(MAX_NODES - 1);
        end else begin
            needed = RC_W'(r_node_count - 5'd1);
        end
    end

    // Deferred entries to answer on leave; the own slot is dropped silently.
    always_comb begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
            flush_mask[i] = r_valid[i] && (int'(r_node_id) != i);
        end
    end

    // Lowest pending entry of the flush.
    always_comb begin
        low_idx = '0;
        for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_idx = TBL_AW'(i);
            end
        end
    end

    assign sid_idx = r_in.sender_id[TBL_AW-1:0];

    // Execution of the captured word.
    always_comb begin
        logic            busy;
        logic            mine;
        logic [RC_W:0]   cnt;
        n_clock   = r_clock;
        n_req     = r_req;
        n_phase   = r_phase;
        n_reply   = r_reply;
        n_entries = r_entries;
        n_valid   = r_valid;
        n_mask    = r_mask;
        has_res   = 1'b0;
        defer_hit = 1'b0;
        flush_go  = 1'b0;
        res_word  = '0;
        res_word.last = 1'b1;
        busy = (r_phase == dmn_pkg::PH_WAIT) || (r_phase == dmn_pkg::PH_INSIDE);
        mine = (r_req < sclk) || ((r_req == sclk) && (r_node_id < r_in.sender_id));
        cnt  = {1'b0, r_reply} + (RC_W+1)'(1);
        unique case (r_in.command)
            dmn_pkg::CMD_REQUEST: begin
                if ((r_phase == dmn_pkg::PH_IDLE) && (r_entries < r_entry_limit)) begin
                    n_req            = r_clock;
                    n_phase          = dmn_pkg::PH_WAIT;
                    n_reply          = '0;
                    has_res          = 1'b1;
                    res_word.out_kind = dmn_pkg::OUT_BROADCAST;
                    res_word.stamp   = 16'(r_clock);
                end
            end
            dmn_pkg::CMD_MESSAGE: begin
                n_clock = clk_upd;
                if (r_in.msg_kind == dmn_pkg::MSG_REQUEST) begin
                    if (busy && mine && (r_in.sender_id != r_node_id)
                            && (int'(r_in.sender_id) < MAX_NODES)) begin
                        defer_hit        = 1'b1;
                        n_valid[sid_idx] = 1'b1;
                    end else begin
                        has_res           = 1'b1;
                        res_word.out_kind = dmn_pkg::OUT_RESPONSE;
                        res_word.dest_id  = r_in.sender_id;
                        res_word.stamp    = 16'(sclk);
                    end
                end else if (r_phase == dmn_pkg::PH_WAIT) begin
                    n_reply = cnt[RC_W-1:0];
                    if (cnt >= {1'b0, needed}) begin
                        n_phase           = dmn_pkg::PH_INSIDE;
                        has_res           = 1'b1;
                        res_word.out_kind = dmn_pkg::OUT_GRANT;
                        res_word.stamp    = 16'(r_req);
                    end
                end
            end
            dmn_pkg::CMD_LEAVE: begin
                if (r_phase == dmn_pkg::PH_INSIDE) begin
                    if (r_entries != 8'hFF) begin
                        n_entries = r_entries + 8'd1;
                    end
                    n_phase  = dmn_pkg::PH_IDLE;
                    n_reply  = '0;
                    n_valid  = '0;
                    n_mask   = flush_mask;
                    flush_go = (flush_mask != '0);
                end
            end
            default: begin
            end
        endcase
    end

    // Deferred stamps; read only where the valid bit was set.
    dmn_ram #(
        .WIDTH(16),
        .DEPTH(TBL_DEPTH)
    ) u_stamp_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.exec && defer_hit),
        .i_waddr(sid_idx),
        .i_wdata(16'(sclk)),
        .i_raddr(low_idx),
        .o_rdata(ram_rdata)
    );

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_word;
        end
    end

    // Configuration registers and protocol state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id     <= dmn_pkg::RST_NODE_ID;
            r_node_count  <= dmn_pkg::RST_NODE_COUNT;
            r_entry_limit <= dmn_pkg::RST_ENTRY_LIMIT;
            r_clock       <= CLOCK_BITS'(dmn_pkg::RST_START_CLOCK);
            r_req         <= '0;
            r_phase       <= dmn_pkg::PH_IDLE;
            r_reply       <= '0;
            r_entries     <= '0;
            r_valid       <= '0;
            r_mask        <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_clock   <= n_clock;
                r_req     <= n_req;
                r_phase   <= n_phase;
                r_reply   <= n_reply;
                r_entries <= n_entries;
                r_valid   <= n_valid;
                r_mask    <= n_mask;
            end else if (i_cmd.emit) begin
                // Drop the entry just answered.
                r_mask <= r_mask & (r_mask - TBL_DEPTH'(1));
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dmn_pkg::CFG_NODE_ID:     r_node_id     <= i_cfg_data[3:0];
                    dmn_pkg::CFG_NODE_COUNT:  r_node_count  <= i_cfg_data[4:0];
                    dmn_pkg::CFG_ENTRY_LIMIT: r_entry_limit <= i_cfg_data[7:0];
                    dmn_pkg::CFG_START_CLOCK: r_clock       <= start_load;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.exec && has_res) || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && has_res) begin
            r_out_word <= res_word;
        end else if (i_cmd.emit) begin
            r_out_word.out_kind <= dmn_pkg::OUT_RESPONSE;
            r_out_word.dest_id  <= 4'(low_idx);
            r_out_word.stamp    <= ram_rdata;
            r_out_word.last     <= ((r_mask & (r_mask - TBL_DEPTH'(1))) == '0);
        end
    end

    assign o_status.out_free   = out_free;
    assign o_status.flush_go   = flush_go;
    assign o_status.last_entry = ((r_mask & (r_mask - TBL_DEPTH'(1))) == '0);
    assign o_out_valid         = r_out_valid;
    assign o_out_word          = r_out_word;

endmodule
`default_nettype wire

>>> src/distributed_mutex_node_unit.sv
`default_nettype none
// A word accepted is captured in the input register, then executed once the output register
// is free; its result goes to the output register. No new word is taken until the last one,
// including any flush of deferred replies, is done; a flush emits one stamp-memory entry at a time.
// Reset: synchronous, active low; configuration returns to its defaults, the clock to 1,
// all deferred entries are cleared at once; the stamp memory itself is not cleared.
// ----------------------------------------------------------------------------
// distributed_mutex_node_unit: one node of Ricart-Agrawala mutual exclusion
// Lamport-clocked requests, deferred replies and enter grants, built as a
// sequencing controller over a datapath with a deferred-stamp memory.
// ----------------------------------------------------------------------------
module distributed_mutex_node_unit #(
    parameter int MAX_NODES  = 16,
    parameter int CLOCK_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire dmn_pkg::t_in_word              i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output dmn_pkg::t_out_word                  o_out_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [dmn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dmn_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dmn_pkg::t_dp_cmd    dp_cmd;
    dmn_pkg::t_dp_status dp_status;

    // Sequencing controller.
    dmn_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd)
    );

    // Datapath with state and deferred table.
    dmn_datapath #(
        .MAX_NODES (MAX_NODES),
        .CLOCK_BITS(CLOCK_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_in_word  (i_in_word),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

endmodule
`default_nettype wire

>>> src/dmn_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmn_checker: port-level checks of the mutex node
// Watches the top level's ports and flags malformed, unstable or post-reset results.
// ----------------------------------------------------------------------------
module dmn_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           o_in_stall,
    input  wire dmn_pkg::t_in_word              i_in_word,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    input  wire dmn_pkg::t_out_word             o_out_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [dmn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dmn_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // Nothing is shown in the cycle after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Broadcasts and grants carry no destination.
    a_dest_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.out_kind != dmn_pkg::OUT_RESPONSE)
            |-> (o_out_word.dest_id == '0))
        else $error("destination set on a broadcast or grant");

    // Broadcasts and grants are the only result of their word.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.out_kind == dmn_pkg::OUT_BROADCAST ||
                        o_out_word.out_kind == dmn_pkg::OUT_GRANT)
            |-> o_out_word.last)
        else $error("broadcast or grant without last flag");

    // Result kind is always a defined code.
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.out_kind == dmn_pkg::OUT_BROADCAST ||
                         o_out_word.out_kind == dmn_pkg::OUT_RESPONSE ||
                         o_out_word.out_kind == dmn_pkg::OUT_GRANT))
        else $error("undefined result kind");

endmodule

bind distributed_mutex_node_unit dmn_checker u_dmn_checker (.*);
`default_nettype wire
